[rtl/core/olq_pkg.sv]
// ----------------------------------------------------------------------------
// olq_pkg: shared types and constants for the ordered list queue
// Opcodes, status codes, sequencer states and the array sizing.
// ----------------------------------------------------------------------------
`default_nettype none
package olq_pkg;
	localparam int DEPTH = 16;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	typedef logic [AW-1:0] addr_t;
	typedef logic [CW-1:0] cnt_t;
	typedef logic signed [31:0] data_t;

	typedef enum logic [3:0] {
		OP_APPEND   = 4'd0,
		OP_POP      = 4'd1,
		OP_INSERT   = 4'd2,
		OP_REMOVE   = 4'd3,
		OP_SEARCH   = 4'd4,
		OP_SWAP     = 4'd5,
		OP_SORT_AFT = 4'd6,
		OP_SORT_ALL = 4'd7,
		OP_CLEAR    = 4'd8
	} op_t;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_IGNORED = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,     // issue read at idx_q
		S_SHL,    // shift-left step: write idx-1 with data at idx
		S_SHR,    // shift-right step: write idx+1 with data at idx
		S_KEY,    // insert: write the new value into its slot
		S_SRCH,   // compare read data with the key
		S_RDA,    // sort: issue read of the first entry of a pass
		S_CMPA,   // sort: latch the first entry as the carried operand
		S_CMPB,   // sort: compare entry idx with the carried one, write idx-1
		S_SWB,    // sort: write the carried entry at the end of the pass
		S_HEAD,   // fetch head for result
		S_HEADW
	} state_t;
endpackage
`default_nettype wire

[rtl/core/ordered_list_queue_with_sort.sv]
// ----------------------------------------------------------------------------
// ordered_list_queue_with_sort: bounded ordered list with sort
// Sequence: append, clear and ignored requests pass S_HEAD and S_HEADW;
// pop/remove add an S_RD/S_SHL pair per shifted entry, insert an S_RD/S_SHR
// pair per shifted entry plus S_KEY, search an S_RD/S_SRCH pair per compared
// entry; swap and sort run S_RDA, S_CMPA, S_RD/S_CMPB pairs and S_SWB per
// pass. Busy is low again in the done cycle, no request is taken while busy;
// results never stall. Reset clears count and control; entries undefined.
// ----------------------------------------------------------------------------
`default_nettype none
module ordered_list_queue_with_sort (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [3:0]            opcode,
	input  wire logic signed [31:0]    value,
	input  wire logic [3:0]            position,
	output logic                       done,
	output logic [1:0]                 status,
	output logic                       found,
	output logic [3:0]                 found_position,
	output logic signed [31:0]         head_value,
	output logic [4:0]                 entry_count
);
	import olq_pkg::*;

	state_t state_q, state_d;
	cnt_t   count_q;
	logic [3:0] op_q;
	data_t  key_q;
	addr_t  idx_q;      // walk index
	addr_t  lo_q;       // sort lower bound
	addr_t  end_q;      // last index of a pass, or insert slot
	cnt_t   pass_q;     // sort passes left
	data_t  a_q;        // carried operand
	data_t  rdata;
	logic   found_q;
	addr_t  fpos_q;
	logic [1:0] status_q;
	logic [1:0] st_c;
	logic   accept;
	logic   take_b;
	cnt_t   pos_c, idx_c, last_c;

	// entry memory: one write, one registered read
	data_t  mem [DEPTH];
	logic   we;
	addr_t  waddr, raddr;
	data_t  wdata;
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

	assign pos_c  = cnt_t'(position);
	assign idx_c  = cnt_t'(idx_q);
	assign last_c = count_q - cnt_t'(1);
	assign accept = start && !busy;
	// swap always moves the later entry down; sort only when it is smaller
	assign take_b = (op_q == OP_SWAP) || (rdata < a_q);

	// request status from opcode, position and count
	always_comb begin
		st_c = ST_DONE;
		case (opcode)
			OP_APPEND: if (count_q >= cnt_t'(DEPTH)) st_c = ST_FULL;
			OP_POP, OP_SEARCH, OP_SORT_ALL: if (count_q == '0) st_c = ST_IGNORED;
			OP_INSERT: begin
				if (pos_c >= count_q) st_c = ST_IGNORED;
				else if (count_q >= cnt_t'(DEPTH)) st_c = ST_FULL;
			end
			OP_REMOVE: if (pos_c + cnt_t'(1) >= count_q) st_c = ST_IGNORED;
			OP_SWAP, OP_SORT_AFT: if (pos_c + cnt_t'(2) >= count_q) st_c = ST_IGNORED;
			OP_CLEAR: ;
			default: st_c = ST_IGNORED;
		endcase
	end

	// next-state logic
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (accept) begin
				state_d = S_HEAD;
				if (st_c == ST_DONE) begin
					case (opcode)
						OP_POP: if (count_q > cnt_t'(1)) state_d = S_RD;
						OP_INSERT: state_d = (pos_c == last_c) ? S_KEY : S_RD;
						OP_REMOVE: if (pos_c + cnt_t'(2) < count_q) state_d = S_RD;
						OP_SEARCH: state_d = S_RD;
						OP_SWAP, OP_SORT_AFT: state_d = S_RDA;
						OP_SORT_ALL: if (count_q > cnt_t'(1)) state_d = S_RDA;
						default: ;
					endcase
				end
			end
			S_RD: begin
				case (op_q)
					OP_POP, OP_REMOVE: state_d = S_SHL;
					OP_INSERT:         state_d = S_SHR;
					OP_SEARCH:         state_d = S_SRCH;
					default:           state_d = S_CMPB;
				endcase
			end
			S_SHL:   state_d = (idx_c == last_c) ? S_HEAD : S_RD;
			S_SHR:   state_d = (idx_q == end_q) ? S_KEY : S_RD;
			S_KEY:   state_d = S_HEAD;
			S_SRCH:  state_d = (rdata == key_q || idx_c == last_c) ? S_HEAD : S_RD;
			S_RDA:   state_d = S_CMPA;
			S_CMPA:  state_d = S_RD;
			S_CMPB:  state_d = (idx_q == end_q) ? S_SWB : S_RD;
			S_SWB:   state_d = (pass_q == cnt_t'(1)) ? S_HEAD : S_RDA;
			S_HEAD:  state_d = S_HEADW;
			S_HEADW: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = rdata;
		raddr = idx_q;
		case (state_q)
			S_IDLE: begin
				waddr = addr_t'(count_q);
				wdata = value;
				we    = accept && opcode == OP_APPEND && st_c == ST_DONE;
			end
			S_SHL: begin we = 1'b1; waddr = idx_q - addr_t'(1); end
			S_SHR: begin we = 1'b1; waddr = idx_q + addr_t'(1); end
			S_KEY: begin we = 1'b1; waddr = end_q; wdata = key_q; end
			S_RDA: raddr = lo_q;
			S_CMPB: begin
				we    = 1'b1;
				waddr = idx_q - addr_t'(1);
				wdata = take_b ? rdata : a_q;
			end
			S_SWB:  begin we = 1'b1; waddr = end_q; wdata = a_q; end
			S_HEAD: raddr = '0;
			default: ;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// sequencer datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0; status_q <= ST_DONE; found_q <= 1'b0; fpos_q <= '0;
			idx_q <= '0; op_q <= '0; key_q <= '0; a_q <= '0;
			lo_q <= '0; end_q <= '0; pass_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (accept) begin
					op_q <= opcode; key_q <= value;
					status_q <= st_c; found_q <= 1'b0; fpos_q <= '0;
					if (st_c == ST_DONE) begin
						case (opcode)
							OP_APPEND: count_q <= count_q + cnt_t'(1);
							OP_POP: if (count_q == cnt_t'(1)) count_q <= '0;
								else idx_q <= addr_t'(1);
							OP_INSERT: begin
								end_q <= addr_t'(pos_c + cnt_t'(1));
								idx_q <= addr_t'(last_c);
							end
							OP_REMOVE: if (pos_c + cnt_t'(2) >= count_q)
									count_q <= count_q - cnt_t'(1);
								else idx_q <= addr_t'(pos_c + cnt_t'(2));
							OP_SEARCH: idx_q <= '0;
							OP_SWAP: begin
								lo_q <= addr_t'(pos_c + cnt_t'(1));
								end_q <= addr_t'(pos_c + cnt_t'(2));
								pass_q <= cnt_t'(1);
							end
							OP_SORT_AFT: begin
								lo_q <= addr_t'(pos_c + cnt_t'(1));
								end_q <= addr_t'(last_c);
								pass_q <= count_q - pos_c - cnt_t'(2);
							end
							OP_SORT_ALL: begin
								lo_q <= '0; end_q <= addr_t'(last_c); pass_q <= last_c;
							end
							OP_CLEAR: count_q <= '0;
							default: ;
						endcase
					end
				end
				S_SHL: begin
					if (idx_c == last_c) count_q <= count_q - cnt_t'(1);
					else idx_q <= idx_q + addr_t'(1);
				end
				S_SHR: if (idx_q != end_q) idx_q <= idx_q - addr_t'(1);
				S_KEY: count_q <= count_q + cnt_t'(1);
				S_SRCH: begin
					if (rdata == key_q) begin
						found_q <= 1'b1; fpos_q <= idx_q;
					end else if (idx_c != last_c) idx_q <= idx_q + addr_t'(1);
				end
				S_CMPA: begin
					a_q <= rdata; idx_q <= lo_q + addr_t'(1);
				end
				S_CMPB: begin
					// keep the larger entry carried forward
					if (!take_b) a_q <= rdata;
					if (idx_q != end_q) idx_q <= idx_q + addr_t'(1);
				end
				S_SWB: pass_q <= pass_q - cnt_t'(1);
				default: ;
			endcase
		end
	end

	// outputs
	assign busy = (state_q != S_IDLE);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0; status <= ST_DONE; found <= 1'b0; found_position <= '0;
			head_value <= '0; entry_count <= '0;
		end else begin
			done <= (state_q == S_HEADW);
			if (state_q == S_HEADW) begin
				status <= status_q;
				found <= found_q;
				found_position <= fpos_q;
				head_value <= (count_q != '0) ? rdata : '0;
				entry_count <= count_q;
			end
		end
	end

	// assertions
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) count_q <= cnt_t'(DEPTH))
		else $error("count overflow");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("done while busy");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted without going busy");
	a_found: assert property (@(posedge clk) disable iff (!arst_n) done && found |-> status == ST_DONE)
		else $error("found with bad status");
endmodule
`default_nettype wire
